// File: rtl/core/ids_pkg.sv
// ids_pkg: shared types and constants for the iterative dominator-set solver
// used by ids_solver and iterative_dominator_sets; depends on nothing else

package ids_pkg;

  localparam int MASK_W    = 32;
  localparam int IDX_W     = 5;
  localparam int CNT_W     = 6;
  localparam int CNT_RESET = 32;

  // request kinds carried in s_tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_SOLVE = 1'b1;

  // one input item as seen by the solver
  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  node_index;
    logic [MASK_W-1:0] pred_mask;
  } ids_req_t;

  // one result item handed from the solver to the output register
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  out_index;
    logic [MASK_W-1:0] dominator_mask;
    logic              is_reachable;
    logic              last;
  } ids_res_t;

endpackage

// File: rtl/core/iterative_dominator_sets.sv
// iterative_dominator_sets: top level with config register and output register
// depends on ids_pkg and ids_solver
//
// A load item (s_tuser 0) writes one predecessor row. A solve item (s_tuser 1)
// runs entirely over the two single-port-read memories: a reachability pass
// reads the predecessor row of each non-entry block and repeats until no
// block is added, the dominator rows are seeded one row per block, each
// dominator pass only reads the predecessor row of an unreachable block and,
// for each reachable non-entry block, scans n rows through the dominator
// memory read port, repeated until a pass changes nothing, and readout reads
// one dominator row per result item, waiting while the output register is
// full. New items are not taken during a solve; after the last result is
// loaded into the output register, new items are accepted while it waits.

module iterative_dominator_sets #(
  parameter int MAX_BLOCKS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,   // blocks_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,     // node_index[4:0], pred_mask[36:5], zero pad
  input  logic        s_tuser,     // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,     // out_index[4:0], dominator_mask[36:5],
                                   // is_reachable[37], zero pad
  output logic        m_tlast      // last
);
  import ids_pkg::*;

  localparam int DEPTH = (MAX_BLOCKS < MASK_W) ? MAX_BLOCKS : MASK_W;

  logic [CNT_W-1:0] blocks_in_use;
  ids_req_t         req;
  ids_res_t         res;
  logic             out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= CNT_W'(CNT_RESET);
    end else if (cfg_we) begin
      blocks_in_use <= cfg_wdata;
    end
  end

  // unpack the input item
  assign req.kind       = s_tuser;
  assign req.node_index = s_tdata[4:0];
  assign req.pred_mask  = s_tdata[36:5];

  ids_solver #(
    .DEPTH (DEPTH)
  ) u_solver (
    .clk           (clk),
    .rst           (rst),
    .blocks_in_use (blocks_in_use),
    .req_valid     (s_tvalid),
    .req_ready     (s_tready),
    .req           (req),
    .out_free      (out_free),
    .res           (res)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= {2'b00, res.is_reachable, res.dominator_mask, res.out_index};
      m_tlast <= res.last;
    end
  end

endmodule

// File: rtl/core/ids_solver.sv
// ids_solver: sequencer plus the predecessor and dominator memories
// depends on ids_pkg; instantiated by iterative_dominator_sets

module ids_solver #(
  parameter int DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ids_pkg::CNT_W-1:0] blocks_in_use,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  ids_pkg::ids_req_t      req,
  input  logic                   out_free,
  output ids_pkg::ids_res_t      res
);
  import ids_pkg::*;

  localparam int AW = $clog2(DEPTH);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_R_RD   = 4'd1;
  localparam logic [3:0] ST_R_CHK  = 4'd2;
  localparam logic [3:0] ST_D_INIT = 4'd3;
  localparam logic [3:0] ST_D_PRD  = 4'd4;
  localparam logic [3:0] ST_D_PLAT = 4'd5;
  localparam logic [3:0] ST_D_SRD  = 4'd6;
  localparam logic [3:0] ST_D_SACC = 4'd7;
  localparam logic [3:0] ST_D_WR   = 4'd8;
  localparam logic [3:0] ST_O_RD   = 4'd9;
  localparam logic [3:0] ST_O_LD   = 4'd10;

  // memories
  logic [MASK_W-1:0] pred_mem [DEPTH];
  logic [MASK_W-1:0] dom_mem  [DEPTH];
  logic [MASK_W-1:0] pred_q;
  logic [MASK_W-1:0] dom_q;

  logic              pred_we;
  logic [AW-1:0]     pred_waddr;
  logic              pred_re;
  logic [AW-1:0]     pred_raddr;
  logic              dom_we;
  logic [AW-1:0]     dom_waddr;
  logic [MASK_W-1:0] dom_wdata;
  logic              dom_re;
  logic [AW-1:0]     dom_raddr;

  // sequencer state
  logic [3:0]        state;
  logic [AW-1:0]     blk;
  logic [AW-1:0]     pidx;
  logic [AW-1:0]     last_blk;
  logic [MASK_W-1:0] all_mask;
  logic [MASK_W-1:0] live;
  logic [MASK_W-1:0] preds;
  logic [MASK_W-1:0] acc;
  logic [MASK_W-1:0] old_row;
  logic              changed;

  logic              accept;
  logic [CNT_W-1:0]  n_sat;
  logic [MASK_W-1:0] blk_bit;
  logic [MASK_W-1:0] new_row;
  logic              upd_chg;
  logic              blk_live;
  logic              hit;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign blk_bit   = MASK_W'(1) << blk;
  assign blk_live  = live[blk];
  assign new_row   = acc | blk_bit;
  assign upd_chg   = (state == ST_D_WR) && (new_row != old_row);
  assign hit       = !blk_live && ((pred_q & live & all_mask) != '0);

  // saturate the block count into 1..DEPTH
  always_comb begin
    n_sat = blocks_in_use;
    if (n_sat == '0) n_sat = CNT_W'(1);
    if (32'(n_sat) > DEPTH) n_sat = CNT_W'(DEPTH);
  end

  // memory port controls
  always_comb begin
    pred_we    = accept && (req.kind == REQ_LOAD) && (32'(req.node_index) < DEPTH);
    pred_waddr = AW'(req.node_index);
    pred_re    = (state == ST_R_RD) || (state == ST_D_PRD);
    pred_raddr = blk;
    dom_we     = 1'b0;
    dom_waddr  = blk;
    dom_wdata  = new_row;
    dom_re     = 1'b0;
    dom_raddr  = blk;
    case (state)
      ST_D_INIT: begin
        dom_we    = 1'b1;
        if (blk == '0) dom_wdata = MASK_W'(1);
        else dom_wdata = blk_live ? all_mask : '0;
      end
      ST_D_WR: begin
        dom_we = upd_chg;
      end
      ST_D_SRD: begin
        dom_re    = 1'b1;
        dom_raddr = pidx;
      end
      ST_O_RD: begin
        dom_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // predecessor memory
  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[pred_waddr] <= req.pred_mask;
    if (pred_re) pred_q <= pred_mem[pred_raddr];
  end

  // dominator memory
  always_ff @(posedge clk) begin
    if (dom_we) dom_mem[dom_waddr] <= dom_wdata;
    if (dom_re) dom_q <= dom_mem[dom_raddr];
  end

  // result toward the output register
  always_comb begin
    res.valid          = (state == ST_O_LD) && out_free;
    res.out_index      = IDX_W'(blk);
    res.dominator_mask = blk_live ? dom_q : '0;
    res.is_reachable   = blk_live;
    res.last           = (blk == last_blk);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      live    <= '0;
      changed <= 1'b0;
      blk     <= '0;
      pidx    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (req.kind == REQ_SOLVE)) begin
            last_blk <= AW'(n_sat - CNT_W'(1));
            all_mask <= MASK_W'((33'd1 << n_sat) - 33'd1);
            live     <= MASK_W'(1);
            changed  <= 1'b0;
            if (n_sat == CNT_W'(1)) begin
              blk   <= '0;
              state <= ST_D_INIT;
            end else begin
              blk   <= AW'(1);
              state <= ST_R_RD;
            end
          end
        end
        // reachability sweep, repeated until a pass adds nothing
        ST_R_RD: begin
          state <= ST_R_CHK;
        end
        ST_R_CHK: begin
          if (hit) live <= live | blk_bit;
          if (blk == last_blk) begin
            changed <= 1'b0;
            if (changed || hit) begin
              blk   <= AW'(1);
              state <= ST_R_RD;
            end else begin
              blk   <= '0;
              state <= ST_D_INIT;
            end
          end else begin
            if (hit) changed <= 1'b1;
            blk   <= blk + AW'(1);
            state <= ST_R_RD;
          end
        end
        // seed the dominator rows
        ST_D_INIT: begin
          if (blk == last_blk) begin
            changed <= 1'b0;
            if (blk == '0) begin
              state <= ST_O_RD;
            end else begin
              blk   <= AW'(1);
              state <= ST_D_PRD;
            end
          end else begin
            blk <= blk + AW'(1);
          end
        end
        // per-block update: read predecessors, scan their rows, write back
        ST_D_PRD, ST_D_WR: begin
          if ((state == ST_D_PRD) && blk_live) begin
            state <= ST_D_PLAT;
          end else if (blk == last_blk) begin
            changed <= 1'b0;
            if (changed || upd_chg) begin
              blk   <= AW'(1);
              state <= ST_D_PRD;
            end else begin
              blk   <= '0;
              state <= ST_O_RD;
            end
          end else begin
            if (upd_chg) changed <= 1'b1;
            blk   <= blk + AW'(1);
            state <= ST_D_PRD;
          end
        end
        ST_D_PLAT: begin
          preds <= pred_q & live & all_mask;
          acc   <= all_mask;
          pidx  <= '0;
          state <= ST_D_SRD;
        end
        ST_D_SRD: begin
          state <= ST_D_SACC;
        end
        ST_D_SACC: begin
          if (preds[pidx]) acc <= acc & dom_q;
          if (pidx == blk) old_row <= dom_q;
          if (pidx == last_blk) begin
            state <= ST_D_WR;
          end else begin
            pidx  <= pidx + AW'(1);
            state <= ST_D_SRD;
          end
        end
        // result readout, one row per result item
        ST_O_RD: begin
          state <= ST_O_LD;
        end
        ST_O_LD: begin
          if (out_free) begin
            if (blk == last_blk) begin
              state <= ST_IDLE;
            end else begin
              blk   <= blk + AW'(1);
              state <= ST_O_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
